// ----- design/cidr_pkg.sv -----
package cidr_pkg;

    localparam int MAX_CONNS   = 64;
    localparam int HANDLE_BITS = 16;
    localparam int ID_W        = 24;
    localparam int HND_W       = 16;
    localparam int IDX_W       = (MAX_CONNS > 1) ? $clog2(MAX_CONNS) : 1;
    localparam int HST_W       = (HANDLE_BITS < HND_W) ? HANDLE_BITS : HND_W;

    localparam logic [ID_W-1:0] ID_RESERVED = 24'hFF_FFFF;
    localparam logic [ID_W-1:0] ID_FIRST    = 24'h00_0001;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_REG    = 2'd1,
        OP_UNREG  = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXISTS    = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic             vld;
        logic             clr;
        logic [ID_W-1:0]  key;
        logic             hit;
        logic [HST_W-1:0] hnd;
        logic             free_vld;
        logic [IDX_W-1:0] free_idx;
    } t_tok;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [ID_W-1:0]  key;
        logic [HST_W-1:0] hnd;
    } t_wr;

    function automatic logic [ID_W-1:0] advance_id(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] n;
        n = id + ID_FIRST;
        if (n == ID_RESERVED) begin
            n = '0;
        end
        return n;
    endfunction

endpackage

// ----- design/connection_id_registry_unit.sv -----
// Connection id registry: a table of up to MAX_CONNS (id, handle) pairs kept in a row of
// cells, with an allocator that proposes the next id not in the table. Each operation sends
// a query through the whole row, one cell per cycle; register, unregister and lookup take
// their result from the query that leaves the last cell. Allocate injects one probe id per
// cycle behind the first and finishes when the first probe that is not in the table leaves
// the row; at most MAX_CONNS + 1 probes are needed.
// One operation is in flight at a time; a finished result waits in the output register while
// the next input transfer is already taken.
module connection_id_registry_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // conn_id[23:0], handle[39:24]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // result_id[23:0], result_handle[39:24]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PASS = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    cidr_pkg::t_op              r_op;
    logic [cidr_pkg::ID_W-1:0]  r_key;
    logic [cidr_pkg::HST_W-1:0] r_hnd;
    logic [cidr_pkg::ID_W-1:0]  r_probe;
    logic [cidr_pkg::ID_W-1:0]  n_probe;
    logic [cidr_pkg::ID_W-1:0]  r_ptr;
    logic [cidr_pkg::ID_W-1:0]  n_ptr;
    cidr_pkg::t_status          r_res_status;
    cidr_pkg::t_status          n_res_status;
    logic [cidr_pkg::ID_W-1:0]  r_res_id;
    logic [cidr_pkg::ID_W-1:0]  n_res_id;
    logic [cidr_pkg::HND_W-1:0] r_res_hnd;
    logic [cidr_pkg::HND_W-1:0] n_res_hnd;
    logic                       r_m_valid;
    cidr_pkg::t_status          r_m_status;
    logic [cidr_pkg::ID_W-1:0]  r_m_id;
    logic [cidr_pkg::HND_W-1:0] r_m_hnd;

    cidr_pkg::t_tok             in_tok;
    cidr_pkg::t_tok             out_tok;
    cidr_pkg::t_wr              wr;
    logic                       flush;
    logic                       s_xfer;
    logic                       out_load;
    cidr_pkg::t_op              s_op;
    logic [cidr_pkg::ID_W-1:0]  s_id;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign s_op          = cidr_pkg::t_op'(s_axis_tuser);
    assign s_id          = s_axis_tdata[cidr_pkg::ID_W-1:0];
    assign out_load      = (r_state == S_FIN) && (!r_m_valid || m_axis_tready);

    always_comb begin
        n_state      = r_state;
        n_probe      = r_probe;
        n_ptr        = r_ptr;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_hnd    = r_res_hnd;
        in_tok       = '0;
        wr           = '0;
        wr.idx       = out_tok.free_idx;
        wr.key       = r_key;
        wr.hnd       = r_hnd;
        flush        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    in_tok.vld = 1'b1;
                    in_tok.clr = (s_op == cidr_pkg::OP_UNREG);
                    if (s_op == cidr_pkg::OP_ALLOC) begin
                        in_tok.key = r_ptr;
                        n_probe    = cidr_pkg::advance_id(r_ptr);
                    end else begin
                        in_tok.key = s_id;
                    end
                    n_state = S_PASS;
                end
            end
            S_PASS: begin
                if (r_op == cidr_pkg::OP_ALLOC) begin
                    in_tok.vld = 1'b1;
                    in_tok.key = r_probe;
                    n_probe    = cidr_pkg::advance_id(r_probe);
                    if (out_tok.vld && !out_tok.hit) begin
                        flush        = 1'b1;
                        n_ptr        = cidr_pkg::advance_id(out_tok.key);
                        n_res_status = cidr_pkg::ST_OK;
                        n_res_id     = out_tok.key;
                        n_res_hnd    = '0;
                        n_state      = S_FIN;
                    end
                end else if (out_tok.vld) begin
                    n_res_id     = r_key;
                    n_res_hnd    = '0;
                    n_res_status = cidr_pkg::ST_OK;
                    case (r_op)
                        cidr_pkg::OP_REG: begin
                            if (out_tok.hit) begin
                                n_res_status = cidr_pkg::ST_EXISTS;
                            end else if (!out_tok.free_vld) begin
                                n_res_status = cidr_pkg::ST_FULL;
                            end else begin
                                wr.en = 1'b1;
                            end
                        end
                        cidr_pkg::OP_UNREG: begin
                            if (!out_tok.hit) begin
                                n_res_status = cidr_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (!out_tok.hit) begin
                                n_res_status = cidr_pkg::ST_NOT_FOUND;
                            end else begin
                                n_res_hnd = cidr_pkg::HND_W'(out_tok.hnd);
                            end
                        end
                    endcase
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    cidr_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (flush),
        .i_tok   (in_tok),
        .i_wr    (wr),
        .o_tok   (out_tok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ptr     <= cidr_pkg::ID_FIRST;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe      <= n_probe;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_hnd    <= n_res_hnd;
        if (s_xfer) begin
            r_op  <= s_op;
            r_key <= s_id;
            r_hnd <= s_axis_tdata[cidr_pkg::ID_W +: cidr_pkg::HST_W];
        end
        if (out_load) begin
            r_m_status <= r_res_status;
            r_m_id     <= r_res_id;
            r_m_hnd    <= r_res_hnd;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_hnd, r_m_id};
    assign m_axis_tuser  = r_m_status;

endmodule

// ----- design/cidr_cell.sv -----
module cidr_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [cidr_pkg::IDX_W-1:0] i_cell_idx,
    input  logic                       i_flush,
    input  cidr_pkg::t_tok             i_tok,
    input  cidr_pkg::t_wr              i_wr,
    output cidr_pkg::t_tok             o_tok
);

    logic                       r_valid;
    logic [cidr_pkg::ID_W-1:0]  r_key;
    logic [cidr_pkg::HST_W-1:0] r_hnd;
    cidr_pkg::t_tok             r_tok;
    cidr_pkg::t_tok             n_tok;
    logic                       hit;
    logic                       wr_here;

    assign hit     = i_tok.vld && r_valid && (r_key == i_tok.key);
    assign wr_here = i_wr.en && (i_wr.idx == i_cell_idx);

    always_comb begin
        n_tok = i_tok;
        if (hit) begin
            n_tok.hit = 1'b1;
            n_tok.hnd = r_hnd;
        end
        if (!i_tok.free_vld && !r_valid) begin
            n_tok.free_vld = 1'b1;
            n_tok.free_idx = i_cell_idx;
        end
        if (i_flush) begin
            n_tok.vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (wr_here) begin
                r_valid <= 1'b1;
            end else if (hit && i_tok.clr) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_key <= i_wr.key;
            r_hnd <= i_wr.hnd;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- design/cidr_chain.sv -----
module cidr_chain (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_flush,
    input  cidr_pkg::t_tok i_tok,
    input  cidr_pkg::t_wr  i_wr,
    output cidr_pkg::t_tok o_tok
);

    cidr_pkg::t_tok tok [0:cidr_pkg::MAX_CONNS];

    assign tok[0] = i_tok;

    for (genvar g = 0; g < cidr_pkg::MAX_CONNS; g++) begin : g_cell
        cidr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (cidr_pkg::IDX_W'(g)),
            .i_flush    (i_flush),
            .i_tok      (tok[g]),
            .i_wr       (i_wr),
            .o_tok      (tok[g+1])
        );
    end

    assign o_tok = tok[cidr_pkg::MAX_CONNS];

endmodule
